FILE: sv/htla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htla_pkg
// shared types and constants of the host table with lru aging
// ----------------------------------------------------------------------------
package htla_pkg;

	localparam int unsigned KEY_W     = 64;
	localparam int unsigned TYPE_W    = 16;
	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned TIME_W    = 48;
	localparam int unsigned TIMEOUT_W = 32;
	localparam int unsigned SLOT_W    = 4;
	localparam int unsigned OUTCOME_W = 2;
	localparam int unsigned ONLINE_W  = 5;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd30000;

	localparam logic CMD_SEEN    = 1'b0;
	localparam logic CMD_REFRESH = 1'b1;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_HIT      = 2'd0,
		OUT_NEW      = 2'd1,
		OUT_RECYCLED = 2'd2,
		OUT_REFRESH  = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic              link_up;
		logic [TIME_W-1:0] last_seen;
		logic [ADDR_W-1:0] address;
		logic [TYPE_W-1:0] dev_type;
		logic [KEY_W-1:0]  key;
	} entry_t;

endpackage
`default_nettype wire

FILE: sv/htla_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htla_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module htla_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       wr_en,
	input  wire [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire [WIDTH-1:0]           wr_data,
	input  wire [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

FILE: sv/host_table_lru_aging_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// host_table_lru_aging_unit
// table of known hosts with lookup, lru recycling and link aging
// ----------------------------------------------------------------------------
// Input beats arrive on s_*: s_tuser is the command (0 host seen, 1 refresh),
// s_tdata carries key, host type, short address, now time and frame time.
// A seen beat looks the key up among the filled entries; a miss takes the
// next free slot or, with the table full, recycles the entry with the
// oldest last-seen time. A refresh beat marks stale hosts down and counts
// the hosts online. Every input beat yields one result beat on m_*.
// The entries live in one ram with a registered read; the sequencer streams
// one entry read per cycle over the filled entries, stopping early on a hit,
// and the next beat is taken once the result has moved into the output
// register. A new input beat is accepted while that result waits, and the
// sequencer holds its next result until the receiver takes the previous one.
// Reset empties the table and restores the stale timeout to 30000 ms; no
// clearing pass is needed. cfg writes are always accepted.
// ----------------------------------------------------------------------------
module host_table_lru_aging_unit #(
	parameter int unsigned MAX_HOSTS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	// configuration: stale_timeout_ms
	input  wire          cfg_valid,
	output logic         cfg_ready,
	input  wire  [31:0]  cfg_data,
	// input beat
	input  wire          s_tvalid,
	output logic         s_tready,
	// device_key[63:0], dev_type[79:64], link_address[95:80],
	// now_time_ms[143:96], frame_time_ms[191:144]
	input  wire  [191:0] s_tdata,
	// command[0]
	input  wire  [0:0]   s_tuser,
	// result beat
	output logic         m_tvalid,
	input  wire          m_tready,
	// slot[3:0], online_count[8:4], zero fill[15:9]
	output logic [15:0]  m_tdata,
	// outcome[1:0]
	output logic [1:0]   m_tuser
);

	localparam int unsigned AW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
	localparam int unsigned CW = $clog2(MAX_HOSTS + 1);
	localparam int unsigned EW = $bits(htla_pkg::entry_t);

	htla_pkg::state_t state_q, state_d;

	logic [htla_pkg::TIMEOUT_W-1:0] timeout_q;

	logic                        cmd_q;
	logic [htla_pkg::KEY_W-1:0]  key_q;
	logic [htla_pkg::TYPE_W-1:0] type_q;
	logic [htla_pkg::ADDR_W-1:0] addr_q;
	logic [htla_pkg::TIME_W-1:0] now_q;
	logic [htla_pkg::TIME_W-1:0] frame_q;

	logic [CW-1:0] filled_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] online_q;
	logic          valid_s1;
	logic [AW-1:0] idx_s1;
	logic [htla_pkg::TIME_W-1:0] min_ts_q;
	logic [AW-1:0] min_idx_q;

	logic [htla_pkg::SLOT_W-1:0]   res_slot_q;
	htla_pkg::outcome_t            res_outcome_q;
	logic [htla_pkg::ONLINE_W-1:0] res_online_q;

	logic                        out_valid_q;
	logic [htla_pkg::SLOT_W-1:0]   out_slot_q;
	htla_pkg::outcome_t            out_outcome_q;
	logic [htla_pkg::ONLINE_W-1:0] out_online_q;

	htla_pkg::entry_t rd_entry;
	logic [EW-1:0]    rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	htla_pkg::entry_t wr_entry;

	logic issue;
	logic match;
	logic stale;
	logic finish;
	logic out_free;
	logic [htla_pkg::TIME_W-1:0] seen_ts;
	logic [htla_pkg::TIME_W-1:0] age;
	logic [CW-1:0]               online_d;
	logic [AW-1:0]               slot_d;
	htla_pkg::outcome_t          outcome_d;

	htla_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_HOSTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign rd_entry  = htla_pkg::entry_t'(rd_data);
	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == htla_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_outcome_q;
	assign m_tdata  = {7'd0, out_online_q, out_slot_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			htla_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = htla_pkg::ST_SCAN;
				end
			end
			htla_pkg::ST_SCAN: begin
				if (finish) begin
					state_d = htla_pkg::ST_DELIVER;
				end
			end
			htla_pkg::ST_DELIVER: begin
				if (out_free) begin
					state_d = htla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = htla_pkg::ST_IDLE;
			end
		endcase
	end

	// scan datapath and write-back
	always_comb begin
		seen_ts   = (now_q != '0) ? now_q : frame_q;
		age       = now_q - rd_entry.last_seen;
		stale     = (rd_entry.last_seen != '0) && (now_q > rd_entry.last_seen)
			&& (age > {16'd0, timeout_q});
		match     = valid_s1 && (cmd_q == htla_pkg::CMD_SEEN) && (rd_entry.key == key_q);
		issue     = (state_q == htla_pkg::ST_SCAN) && (idx_q < filled_q) && !match;
		finish    = (state_q == htla_pkg::ST_SCAN) && (match || (!issue && !valid_s1));
		online_d  = online_q;
		wr_en     = 1'b0;
		wr_addr   = idx_s1;
		wr_entry  = rd_entry;
		slot_d    = '0;
		outcome_d = htla_pkg::OUT_HIT;
		if (state_q == htla_pkg::ST_SCAN) begin
			if (cmd_q == htla_pkg::CMD_REFRESH) begin
				outcome_d = htla_pkg::OUT_REFRESH;
				if (valid_s1) begin
					wr_entry.link_up = rd_entry.link_up && !stale;
					wr_en            = stale && rd_entry.link_up;
					online_d         = online_q + CW'(wr_entry.link_up);
				end
			end else if (match) begin
				slot_d             = idx_s1;
				wr_en              = 1'b1;
				wr_addr            = idx_s1;
				wr_entry.link_up   = 1'b1;
				wr_entry.last_seen = seen_ts;
				wr_entry.address   = addr_q;
			end else if (finish) begin
				if (filled_q == CW'(MAX_HOSTS)) begin
					slot_d    = min_idx_q;
					outcome_d = htla_pkg::OUT_RECYCLED;
				end else begin
					slot_d    = filled_q[AW-1:0];
					outcome_d = htla_pkg::OUT_NEW;
				end
				wr_en              = 1'b1;
				wr_addr            = slot_d;
				wr_entry.link_up   = 1'b1;
				wr_entry.last_seen = seen_ts;
				wr_entry.address   = addr_q;
				wr_entry.dev_type  = type_q;
				wr_entry.key       = key_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= htla_pkg::ST_IDLE;
			timeout_q   <= htla_pkg::TIMEOUT_RESET;
			filled_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				timeout_q <= cfg_data;
			end
			if (finish && (cmd_q == htla_pkg::CMD_SEEN) && !match
					&& (filled_q != CW'(MAX_HOSTS))) begin
				filled_q <= filled_q + 1'b1;
			end
			if ((state_q == htla_pkg::ST_DELIVER) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[AW-1:0];
		if (s_tvalid && s_tready) begin
			cmd_q    <= s_tuser[0];
			key_q    <= s_tdata[63:0];
			type_q   <= s_tdata[79:64];
			addr_q   <= s_tdata[95:80];
			now_q    <= s_tdata[143:96];
			frame_q  <= s_tdata[191:144];
			idx_q    <= '0;
			online_q <= '0;
		end else begin
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			online_q <= online_d;
		end
		if (valid_s1 && (cmd_q == htla_pkg::CMD_SEEN)
				&& ((idx_s1 == '0) || (rd_entry.last_seen < min_ts_q))) begin
			min_ts_q  <= rd_entry.last_seen;
			min_idx_q <= idx_s1;
		end
		if (finish) begin
			res_slot_q    <= htla_pkg::SLOT_W'(slot_d);
			res_outcome_q <= outcome_d;
			res_online_q  <= (cmd_q == htla_pkg::CMD_REFRESH)
				? htla_pkg::ONLINE_W'(online_q) : '0;
		end
		if ((state_q == htla_pkg::ST_DELIVER) && out_free) begin
			out_slot_q    <= res_slot_q;
			out_outcome_q <= res_outcome_q;
			out_online_q  <= res_online_q;
		end
	end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the host table with lru aging against a cycle-free table mirror
// ----------------------------------------------------------------------------
// A short table of directed beats covers the empty table, extreme keys and
// times, hits, the stale-age boundary, filling the table and recycling the
// oldest entry. Random beats follow over several stale timeouts, drawn from
// a small key pool so that hits, new slots and recycling all occur. Every
// beat is run through the mirror and each result beat is compared with the
// oldest prediction. The sender idles in bursts and the receiver stalls on
// patterns, with one long receiver hold and drain pauses between phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned HOSTS      = 16;
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned PHASE_LEN  = 240;
	localparam int unsigned POOL_SIZE  = 24;
	localparam logic [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic                        cmd;
		logic [htla_pkg::KEY_W-1:0]  key;
		logic [htla_pkg::TYPE_W-1:0] htype;
		logic [htla_pkg::ADDR_W-1:0] addr;
		logic [htla_pkg::TIME_W-1:0] now_ms;
		logic [htla_pkg::TIME_W-1:0] frame_ms;
	} host_item_t;

	typedef struct {
		logic [htla_pkg::SLOT_W-1:0]   slot;
		htla_pkg::outcome_t            outcome;
		logic [htla_pkg::ONLINE_W-1:0] online;
	} host_result_t;

	typedef struct {
		host_item_t   item;
		bit           typed;
		host_result_t want;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;
	logic [1:0]   m_tuser;

	// table mirror
	logic [htla_pkg::KEY_W-1:0]     mirror_key  [HOSTS];
	logic [htla_pkg::TIME_W-1:0]    mirror_seen [HOSTS];
	logic                           mirror_up   [HOSTS];
	int unsigned                    mirror_filled;
	logic [htla_pkg::TIMEOUT_W-1:0] mirror_timeout;

	host_result_t  expected_results[$];
	host_result_t  want_beat;
	int unsigned   error_count;
	int unsigned   idle_cycles;
	int unsigned   burst_left;
	int unsigned   hold_left;
	int unsigned   pattern_left;
	int unsigned   ready_mode;
	logic [31:0]   ready_pattern;
	bit            long_hold_req;
	logic [47:0]   wall_ms;
	logic [63:0]   key_pool [POOL_SIZE];
	int unsigned   pool_span;

	host_table_lru_aging_unit #(
		.MAX_HOSTS(HOSTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic host_result_t predict_host_result(host_item_t it);
		host_result_t r;
		int unsigned  idx;
		int unsigned  online;
		bit           hit;
		r.slot = '0;
		r.outcome = htla_pkg::OUT_HIT;
		r.online = '0;
		hit = 1'b0;
		idx = 0;
		online = 0;
		if (it.cmd == htla_pkg::CMD_REFRESH) begin
			for (int i = 0; i < mirror_filled; i++) begin
				if (mirror_seen[i] != 0 && it.now_ms > mirror_seen[i] &&
				    (it.now_ms - mirror_seen[i]) > {16'd0, mirror_timeout})
					mirror_up[i] = 1'b0;
				if (mirror_up[i])
					online++;
			end
			r.outcome = htla_pkg::OUT_REFRESH;
			r.online = online[htla_pkg::ONLINE_W-1:0];
			return r;
		end
		for (int i = 0; i < mirror_filled; i++) begin
			if (!hit && mirror_key[i] == it.key) begin
				idx = i;
				hit = 1'b1;
			end
		end
		if (!hit) begin
			if (mirror_filled >= HOSTS) begin
				idx = 0;
				for (int i = 1; i < HOSTS; i++) begin
					if (mirror_seen[i] < mirror_seen[idx])
						idx = i;
				end
				r.outcome = htla_pkg::OUT_RECYCLED;
			end else begin
				idx = mirror_filled;
				mirror_filled++;
				r.outcome = htla_pkg::OUT_NEW;
			end
			mirror_key[idx] = it.key;
		end
		mirror_up[idx] = 1'b1;
		mirror_seen[idx] = (it.now_ms != 0) ? it.now_ms : it.frame_ms;
		r.slot = idx[htla_pkg::SLOT_W-1:0];
		return r;
	endfunction

	function automatic dir_row_t dir_row(logic cmd, logic [63:0] key, logic [15:0] htype,
			logic [15:0] addr, logic [47:0] now_ms, logic [47:0] frame_ms, bit typed,
			logic [3:0] slot, htla_pkg::outcome_t oc, logic [4:0] online);
		dir_row_t d;
		d.item.cmd = cmd;
		d.item.key = key;
		d.item.htype = htype;
		d.item.addr = addr;
		d.item.now_ms = now_ms;
		d.item.frame_ms = frame_ms;
		d.typed = typed;
		d.want.slot = slot;
		d.want.outcome = oc;
		d.want.online = online;
		return d;
	endfunction

	function automatic logic [47:0] random_time();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic host_item_t random_item();
		host_item_t  it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			wall_ms = wall_ms;
		else if (pick < 70)
			wall_ms = wall_ms + $urandom_range(0, 200);
		else if (pick < 90)
			wall_ms = wall_ms + $urandom_range(0, 40000);
		else
			wall_ms = wall_ms + 32'($urandom);
		it.cmd = ($urandom_range(0, 99) < 15) ? htla_pkg::CMD_REFRESH : htla_pkg::CMD_SEEN;
		if ($urandom_range(0, 99) < 85)
			it.key = key_pool[$urandom_range(0, pool_span - 1)];
		else
			it.key = {32'($urandom), 32'($urandom)};
		it.htype = 16'($urandom);
		it.addr = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 12)
			it.now_ms = '0;
		else if (pick < 20)
			it.now_ms = random_time();
		else
			it.now_ms = wall_ms;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			it.frame_ms = wall_ms;
		else if (pick < 80)
			it.frame_ms = random_time();
		else
			it.frame_ms = '0;
		return it;
	endfunction

	task automatic send_beat(host_item_t it, bit typed, host_result_t want);
		host_result_t predicted;
		int unsigned  gap;
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {it.frame_ms, it.now_ms, it.addr, it.htype, it.key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_host_result(it);
		expected_results.push_back(typed ? want : predicted);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			if ($urandom_range(0, 99) < 40)
				gap = 0;
			else if ($urandom_range(0, 99) < 90)
				gap = $urandom_range(1, 12);
			else
				gap = $urandom_range(13, 30);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (HOSTS + 4) @(posedge clk);
	endtask

	task automatic write_timeout(logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mirror_timeout = value;
		cfg_valid <= 1'b0;
	endtask

	// receiver stall patterns, with a long hold on request
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		pattern_left = 0;
		ready_mode = 0;
		ready_pattern = '1;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(16, 200);
					ready_mode = $urandom_range(0, 3);
					ready_pattern = $urandom;
				end
				pattern_left--;
				case (ready_mode)
					0: m_tready <= 1'b1;
					1: begin
						m_tready <= ready_pattern[0];
						ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
					end
					2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%t unexpected result beat: slot %0d outcome %0d online %0d",
					$time, m_tdata[3:0], m_tuser, m_tdata[8:4]);
				error_count++;
			end else begin
				want_beat = expected_results.pop_front();
				if (m_tdata[3:0] !== want_beat.slot) begin
					$display("%t slot mismatch: expected %0d, actual %0d",
						$time, want_beat.slot, m_tdata[3:0]);
					error_count++;
				end
				if (m_tuser !== want_beat.outcome) begin
					$display("%t outcome mismatch: expected %0d, actual %0d",
						$time, want_beat.outcome, m_tuser);
					error_count++;
				end
				if (m_tdata[8:4] !== want_beat.online) begin
					$display("%t online count mismatch: expected %0d, actual %0d",
						$time, want_beat.online, m_tdata[8:4]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%t no beat accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		dir_row_t     rows[$];
		host_item_t   it;
		host_result_t none;
		logic [31:0]  timeout_plan [5];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		long_hold_req = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		mirror_filled = 0;
		mirror_timeout = htla_pkg::TIMEOUT_RESET;
		wall_ms = 48'd100000;
		pool_span = POOL_SIZE;
		none.slot = '0;
		none.outcome = htla_pkg::OUT_HIT;
		none.online = '0;
		for (int i = 0; i < HOSTS; i++) begin
			mirror_key[i] = '0;
			mirror_seen[i] = '0;
			mirror_up[i] = 1'b0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = {32'($urandom), 32'($urandom)};
		timeout_plan[0] = 32'd0;
		timeout_plan[1] = 32'hFFFF_FFFF;
		timeout_plan[2] = 32'd1000;
		timeout_plan[3] = $urandom_range(1, 100000);
		timeout_plan[4] = htla_pkg::TIMEOUT_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extreme keys and times, stale boundary at the reset timeout
		rows.push_back(dir_row(htla_pkg::CMD_REFRESH, '0, '0, '0, '0, '0,
			1, 4'd0, htla_pkg::OUT_REFRESH, 5'd0));
		rows.push_back(dir_row(htla_pkg::CMD_SEEN, '0, '0, '0, '0, '0,
			1, 4'd0, htla_pkg::OUT_NEW, 5'd0));
		rows.push_back(dir_row(htla_pkg::CMD_SEEN, '1, 16'hFFFF, 16'hFFFF, TIME_MAX, TIME_MAX,
			1, 4'd1, htla_pkg::OUT_NEW, 5'd0));
		rows.push_back(dir_row(htla_pkg::CMD_SEEN, '0, 16'h5A5A, 16'h0102, '0, 48'd1000,
			1, 4'd0, htla_pkg::OUT_HIT, 5'd0));
		rows.push_back(dir_row(htla_pkg::CMD_SEEN, 64'd1, 16'h1234, 16'h00FF, '0, '0,
			1, 4'd2, htla_pkg::OUT_NEW, 5'd0));
		rows.push_back(dir_row(htla_pkg::CMD_REFRESH, '1, '1, '1, '0, '1,
			1, 4'd0, htla_pkg::OUT_REFRESH, 5'd3));
		rows.push_back(dir_row(htla_pkg::CMD_REFRESH, '0, '0, '0, 48'd31000, '0,
			1, 4'd0, htla_pkg::OUT_REFRESH, 5'd3));
		rows.push_back(dir_row(htla_pkg::CMD_REFRESH, '0, '0, '0, 48'd31001, '0,
			1, 4'd0, htla_pkg::OUT_REFRESH, 5'd2));
		rows.push_back(dir_row(htla_pkg::CMD_SEEN, '1, 16'h0000, 16'h8000, 48'd1, '0,
			1, 4'd1, htla_pkg::OUT_HIT, 5'd0));
		rows.push_back(dir_row(htla_pkg::CMD_REFRESH, '0, '0, '0, TIME_MAX, '0,
			1, 4'd0, htla_pkg::OUT_REFRESH, 5'd1));
		for (int i = 3; i < HOSTS; i++)
			rows.push_back(dir_row(htla_pkg::CMD_SEEN, 64'h100 + i, 16'(i), 16'(i * 3),
				48'd40000 + i * 7, random_time(), 0, 4'd0, htla_pkg::OUT_HIT, 5'd0));
		rows.push_back(dir_row(htla_pkg::CMD_SEEN, 64'hDEAD_BEEF_0000_0001, 16'hBEEF,
			16'h4321, 48'd50000, '0, 0, 4'd0, htla_pkg::OUT_HIT, 5'd0));
		rows.push_back(dir_row(htla_pkg::CMD_REFRESH, '0, '0, '0, 48'd70050, '0,
			0, 4'd0, htla_pkg::OUT_HIT, 5'd0));
		foreach (rows[i])
			send_beat(rows[i].item, rows[i].typed, rows[i].want);

		for (int phase = 0; phase < 5; phase++) begin
			drain_results();
			write_timeout(timeout_plan[phase]);
			pool_span = $urandom_range(12, POOL_SIZE);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (phase == 1 && n == 50)
					long_hold_req = 1'b1;
				if (phase == 2 && n == 120)
					drain_results();
				it = random_item();
				send_beat(it, 0, none);
			end
		end

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (HOSTS + 8) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
